// ===== rtl/msct_pkg.sv =====
// Shared types and constants for the minute-step countdown timer core.
// Depends on nothing; imported by minute_step_countdown_timer_core.
`default_nettype none

package msct_pkg;

  // Command codes carried in the request user field.
  typedef enum logic [3:0] {
    CMD_TICK    = 4'd0,
    CMD_START   = 4'd1,
    CMD_STOP    = 4'd2,
    CMD_TOGGLE  = 4'd3,
    CMD_RESTART = 4'd4,
    CMD_ADD1    = 4'd5,
    CMD_SUB1    = 4'd6,
    CMD_ADD5    = 4'd7,
    CMD_SUB5    = 4'd8
  } cmd_t;

  localparam int unsigned SECS_W = 16;
  // Whole minutes held in a 16-bit second count: at most 1092.
  localparam int unsigned MINS_W = 11;
  localparam int unsigned SECS_PER_MIN = 60;
  localparam logic [MINS_W-1:0] BIG_STEP = 11'd5;
  localparam logic [MINS_W-1:0] SMALL_STEP = 11'd1;

  // Reciprocal of 60 scaled by 2^22, rounded up; exact floor for 16-bit values.
  localparam int unsigned RECIP_SHIFT = 22;
  localparam logic [16:0] RECIP_60 = 17'd69906;

  typedef struct packed {
    logic [SECS_W-1:0] remaining;
    logic [SECS_W-1:0] preset;
    logic              running;
    logic              paused;
  } timer_state_t;

endpackage

`default_nettype wire

// ===== rtl/minute_step_countdown_timer_core.sv =====
// Minute-step countdown timer core: input register, command logic, result register.
// Depends on msct_pkg for command codes, widths and the state record.
//
// Each request carries one command and yields exactly one result, which shows the
// timer state after that command. A request is taken in every cycle as long as the
// result register is empty or being drained in the same cycle, so the sustained
// rate is one command per clock. An accepted request waits in the input register
// until the result register can take it, and its result is then offered from the
// result register. The
// minute commands truncate the remaining time to whole minutes with one 16x17
// reciprocal multiply, which is the longest path between the two registers. All
// stored second counts saturate at MAX_MINUTES times 60, limited to 65535.
`default_nettype none

module minute_step_countdown_timer_core #(
  parameter int unsigned MAX_MINUTES = 1023
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Command requests.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,  // [15:0] start_seconds
  input  wire logic [3:0]  in_tuser,  // [3:0] cmd
  // Timer results.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata  // [15:0] remaining_seconds, [31:16] preset_seconds,
                                      // [32] is_running, [33] is_paused, [34] finished,
                                      // [39:35] zero
);
  import msct_pkg::*;

  localparam int unsigned MAX_SECS_RAW = MAX_MINUTES * SECS_PER_MIN;
  localparam logic [SECS_W-1:0] MAX_SECS =
    (MAX_SECS_RAW > 65535) ? 16'hFFFF : SECS_W'(MAX_SECS_RAW);

  // Input register.
  logic              s1_valid_r;
  cmd_t              s1_cmd_r;
  logic [SECS_W-1:0] s1_secs_r;
  logic              s1_adv;

  // Timer state.
  timer_state_t st_r;
  timer_state_t st_nxt;
  logic         done_nxt;

  // Result register.
  logic         out_valid_r;
  timer_state_t out_st_r;
  logic         out_done_r;

  // Minute arithmetic.
  logic [32:0]          mins_prod;
  logic [MINS_W-1:0]    mins;
  logic [MINS_W-1:0]    step_k;
  logic [MINS_W:0]      up_mins;
  logic [MINS_W+6:0]    up_secs;
  logic [SECS_W-1:0]    up_clamped;
  logic [MINS_W-1:0]    dn_mins;
  logic [MINS_W+5:0]    dn_secs;
  logic [SECS_W-1:0]    dn_result;
  logic [SECS_W-1:0]    start_clamped;

  // Handshake: the input stage moves on when the result register can take it.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r  <= cmd_t'(in_tuser[3:0]);
      s1_secs_r <= in_tdata[15:0];
    end
  end

  // Truncate remaining time to whole minutes: x * ceil(2^22 / 60) >> 22.
  assign mins_prod = 33'(st_r.remaining) * 33'(RECIP_60);
  assign mins      = mins_prod[RECIP_SHIFT +: MINS_W];

  assign step_k = (s1_cmd_r == CMD_ADD5 || s1_cmd_r == CMD_SUB5) ? BIG_STEP : SMALL_STEP;

  // Step up, times 60 as 64 minus 4, then saturate.
  assign up_mins    = {1'b0, mins} + {1'b0, step_k};
  assign up_secs    = {up_mins, 6'b0} - {4'b0, up_mins, 2'b0};
  assign up_clamped = (up_secs > (MINS_W+7)'(MAX_SECS)) ? MAX_SECS : up_secs[SECS_W-1:0];

  // Step down floors at zero; the result never exceeds the current count.
  assign dn_mins   = mins - step_k;
  assign dn_secs   = {dn_mins, 6'b0} - {4'b0, dn_mins, 2'b0};
  assign dn_result = (mins >= step_k) ? dn_secs[SECS_W-1:0] : '0;

  assign start_clamped = (s1_secs_r > MAX_SECS) ? MAX_SECS : s1_secs_r;

  // Command decode and next state.
  always_comb begin
    st_nxt   = st_r;
    done_nxt = 1'b0;
    case (s1_cmd_r)
      CMD_TICK: begin
        if (st_r.running && !st_r.paused && st_r.remaining != '0) begin
          st_nxt.remaining = st_r.remaining - 1'b1;
          if (st_r.remaining == SECS_W'(1)) begin
            done_nxt       = 1'b1;
            st_nxt.running = 1'b0;
          end
        end
      end
      CMD_START: begin
        st_nxt.remaining = start_clamped;
        st_nxt.paused    = 1'b0;
        st_nxt.running   = 1'b1;
      end
      CMD_STOP: begin
        st_nxt.running = 1'b0;
      end
      CMD_TOGGLE: begin
        if (st_r.running) begin
          st_nxt.paused = !st_r.paused;
        end else if (st_r.preset != '0) begin
          st_nxt.remaining = st_r.preset;
          st_nxt.paused    = 1'b0;
          st_nxt.running   = 1'b1;
        end
      end
      CMD_RESTART: begin
        st_nxt.remaining = st_r.preset;
        st_nxt.paused    = 1'b0;
        st_nxt.running   = 1'b1;
      end
      CMD_ADD1, CMD_ADD5: begin
        st_nxt.remaining = up_clamped;
        st_nxt.preset    = up_clamped;
      end
      CMD_SUB1, CMD_SUB5: begin
        st_nxt.remaining = dn_result;
        st_nxt.preset    = dn_result;
        if (dn_result == '0) begin
          st_nxt.running = 1'b0;
        end
      end
      default: begin
        st_nxt = st_r;
      end
    endcase
  end

  // State commits when the command moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_st_r   <= st_nxt;
      out_done_r <= done_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_done_r, out_st_r.paused, out_st_r.running,
                       out_st_r.preset, out_st_r.remaining};

  // Stored counts never exceed the saturation limit.
  a_remaining_limit: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.remaining <= MAX_SECS && st_r.preset <= MAX_SECS)
    else $error("timer count above saturation limit");

  // A finished result reports a stopped timer at zero.
  a_finished_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> !out_st_r.running && out_st_r.remaining == '0)
    else $error("finished flag with timer not stopped at zero");

  // A new request is taken only when the held one moves on.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && s1_valid_r |-> s1_adv)
    else $error("input register overwritten");

  // State changes only when a command commits.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(st_r))
    else $error("timer state changed without a command");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for minute_step_countdown_timer_core: predicts every timer result
// from the accepted commands and compares it field by field with the result stream.
// Depends on msct_pkg and minute_step_countdown_timer_core.
`timescale 1ns / 1ps

module testbench;
  import msct_pkg::*;

  localparam int unsigned MAX_MINUTES = 1023;
  localparam int unsigned MAX_SECS =
    (MAX_MINUTES * SECS_PER_MIN > 65535) ? 65535 : MAX_MINUTES * SECS_PER_MIN;
  localparam int unsigned UNUSED_CMD_LO = 9;
  localparam int unsigned UNUSED_CMD_HI = 15;
  localparam int CLK_HALF = 4;
  localparam int RESET_CYCLES = 8;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 8;
  localparam int DRAIN_LIMIT = 5000;
  localparam int CYCLE_LIMIT = 250000;

  typedef struct packed {
    logic [15:0] remaining;
    logic [15:0] preset;
    logic        running;
    logic        paused;
    logic        finished;
  } timer_result_t;

  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_SPARSE
  } rx_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;  // [15:0] start_seconds
  logic [3:0]  in_tuser;  // [3:0] cmd
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata; // [15:0] remaining, [31:16] preset, [32] running,
                          // [33] paused, [34] finished

  // Predicted timer state.
  logic [15:0] timer_remaining;
  logic [15:0] timer_preset;
  logic        pred_running;
  logic        timer_paused;

  timer_result_t pending_results[$];
  int error_count;
  int burst_left;
  int cycle_count;
  bit hold_request;

  minute_step_countdown_timer_core #(
    .MAX_MINUTES(MAX_MINUTES)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  // Clock generator.
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Saturate a second count at the largest storable duration.
  function automatic logic [15:0] clamp_seconds(input int unsigned secs);
    return (secs > MAX_SECS) ? MAX_SECS[15:0] : secs[15:0];
  endfunction

  function automatic void load_timer(input logic [15:0] secs);
    timer_remaining = clamp_seconds(secs);
    timer_paused = 1'b0;
    pred_running = 1'b1;
  endfunction

  // Truncate to whole minutes, then step the count by k minutes up or down.
  function automatic void step_minutes(input int unsigned k, input bit down);
    int unsigned mins;
    mins = timer_remaining / SECS_PER_MIN;
    if (!down) begin
      timer_remaining = clamp_seconds((mins + k) * SECS_PER_MIN);
    end else begin
      timer_remaining = (mins >= k) ? clamp_seconds((mins - k) * SECS_PER_MIN) : 16'd0;
      if (timer_remaining == 16'd0) pred_running = 1'b0;
    end
    timer_preset = timer_remaining;
  endfunction

  // Apply one command to the predicted state and return the result it shows.
  function automatic timer_result_t advance_timer(input logic [3:0] cmd,
                                                  input logic [15:0] secs);
    timer_result_t res;
    logic done;
    done = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (pred_running && !timer_paused && timer_remaining != 16'd0) begin
          timer_remaining = timer_remaining - 16'd1;
          if (timer_remaining == 16'd0) begin
            done = 1'b1;
            pred_running = 1'b0;
          end
        end
      end
      CMD_START: load_timer(secs);
      CMD_STOP: pred_running = 1'b0;
      CMD_TOGGLE: begin
        if (pred_running) timer_paused = !timer_paused;
        else if (timer_preset != 16'd0) load_timer(timer_preset);
      end
      CMD_RESTART: load_timer(timer_preset);
      CMD_ADD1: step_minutes(SMALL_STEP, 1'b0);
      CMD_SUB1: step_minutes(SMALL_STEP, 1'b1);
      CMD_ADD5: step_minutes(BIG_STEP, 1'b0);
      CMD_SUB5: step_minutes(BIG_STEP, 1'b1);
      default: ;
    endcase
    res.remaining = timer_remaining;
    res.preset = timer_preset;
    res.running = pred_running;
    res.paused = timer_paused;
    res.finished = done;
    return res;
  endfunction

  // Record each accepted request's prediction, then check each accepted result.
  always @(posedge clk) begin
    timer_result_t exp_res;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pending_results.push_back(advance_timer(in_tuser, in_tdata));
      end
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: remaining %0d preset %0d",
                 out_tdata[15:0], out_tdata[31:16]);
          error_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (out_tdata[15:0] !== exp_res.remaining) begin
            $error("remaining_seconds: expected %0d, actual %0d",
                   exp_res.remaining, out_tdata[15:0]);
            error_count++;
          end
          if (out_tdata[31:16] !== exp_res.preset) begin
            $error("preset_seconds: expected %0d, actual %0d",
                   exp_res.preset, out_tdata[31:16]);
            error_count++;
          end
          if (out_tdata[32] !== exp_res.running) begin
            $error("is_running: expected %0b, actual %0b", exp_res.running, out_tdata[32]);
            error_count++;
          end
          if (out_tdata[33] !== exp_res.paused) begin
            $error("is_paused: expected %0b, actual %0b", exp_res.paused, out_tdata[33]);
            error_count++;
          end
          if (out_tdata[34] !== exp_res.finished) begin
            $error("finished: expected %0b, actual %0b", exp_res.finished, out_tdata[34]);
            error_count++;
          end
        end
      end
    end
  end

  // Result-side ready: a long hold-off on request, otherwise a changing stall pattern.
  initial begin
    int hold_left;
    int mode_left;
    rx_mode_t rx_mode;
    hold_left = 0;
    mode_left = 0;
    rx_mode = RX_ALWAYS;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(RX_ALWAYS, RX_SPARSE));
          mode_left = $urandom_range(16, 120);
        end
        mode_left--;
        case (rx_mode)
          RX_ALWAYS: out_tready <= 1'b1;
          RX_RANDOM: out_tready <= 1'($urandom_range(0, 1));
          default:   out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Run watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // Send one request, idling between bursts, and wait until it is accepted.
  task automatic send_request(input logic [3:0] cmd, input logic [15:0] secs);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        in_tdata <= 16'($urandom);
        in_tuser <= 4'($urandom);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= secs;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop offering requests until every predicted result has arrived or the drain limit runs out.
  task automatic wait_for_results();
    int waited;
    waited = 0;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // Start value for a start request: mostly short runs, sometimes any 16-bit value.
  function automatic logic [15:0] random_seconds();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return 16'($urandom_range(0, 90));
    else if (pick < 9) return 16'($urandom_range(0, MAX_SECS));
    else return 16'($urandom);
  endfunction

  // Weighted command choice; ticks dominate so that runs reach zero.
  function automatic logic [3:0] random_command();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return CMD_TICK;
    else if (pick < 60) return CMD_START;
    else if (pick < 64) return CMD_STOP;
    else if (pick < 70) return CMD_TOGGLE;
    else if (pick < 74) return CMD_RESTART;
    else if (pick < 79) return CMD_ADD1;
    else if (pick < 85) return CMD_SUB1;
    else if (pick < 89) return CMD_ADD5;
    else if (pick < 95) return CMD_SUB5;
    else return 4'($urandom_range(UNUSED_CMD_LO, UNUSED_CMD_HI));
  endfunction

  task automatic send_random(input int count);
    logic [3:0] cmd;
    repeat (count) begin
      cmd = random_command();
      send_request(cmd, (cmd == CMD_START) ? random_seconds() : 16'($urandom));
    end
  endtask

  // Edge cases of every command, one after another.
  task automatic test_directed();
    send_request(CMD_TICK, 16'd0);
    send_request(CMD_TOGGLE, 16'd0);        // not running and no preset: no change
    send_request(CMD_RESTART, 16'hFFFF);    // loads a zero preset and runs at zero
    send_request(CMD_TICK, 16'd0);          // running at zero: no finish
    send_request(CMD_STOP, 16'd0);
    send_request(CMD_START, 16'd0);
    send_request(CMD_START, 16'd3);
    repeat (4) send_request(CMD_TICK, 16'hFFFF);
    send_request(CMD_START, 16'hFFFF);      // clamps to the maximum
    send_request(CMD_ADD1, 16'd0);          // saturates
    send_request(CMD_ADD5, 16'd0);
    send_request(CMD_TOGGLE, 16'd0);        // pause
    send_request(CMD_TICK, 16'd0);          // held by pause
    send_request(CMD_STOP, 16'd0);          // pause bit survives the stop
    send_request(CMD_TOGGLE, 16'd0);        // starts from the preset
    send_request(CMD_SUB5, 16'd0);
    send_request(CMD_START, 16'd59);
    send_request(CMD_SUB1, 16'd0);          // floors at zero and stops
    send_request(CMD_START, 16'd125);
    send_request(CMD_ADD1, 16'd0);
    send_request(CMD_SUB5, 16'd0);
    send_request(4'(UNUSED_CMD_LO), 16'hAAAA);
    send_request(4'(UNUSED_CMD_HI), 16'h5555);
  endtask

  // Well-formed runs: a start, then mostly ticks with a few pauses and steps.
  task automatic test_countdown_runs(input int runs);
    int ticks;
    int pick;
    repeat (runs) begin
      send_request(CMD_START, 16'($urandom_range(1, 20)));
      ticks = $urandom_range(5, 25);
      repeat (ticks) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) send_request(CMD_TOGGLE, 16'($urandom));
        else if (pick == 1) send_request(CMD_ADD1, 16'($urandom));
        else if (pick == 2) send_request(CMD_SUB1, 16'($urandom));
        else send_request(CMD_TICK, 16'($urandom));
      end
    end
  endtask

  // Long result stall while requests keep coming, so the input side backs up.
  task automatic test_backpressure();
    hold_request = 1'b1;
    send_random(80);
  endtask

  // Pause the sender until everything has drained, then resume.
  task automatic test_drain_pause();
    send_random(30);
    wait_for_results();
    send_random(30);
    wait_for_results();
  endtask

  initial begin
    int waited;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    hold_request = 1'b0;
    burst_left = 0;
    error_count = 0;
    timer_remaining = '0;
    timer_preset = '0;
    pred_running = 1'b0;
    timer_paused = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_countdown_runs(25);
    send_random(880);
    test_backpressure();
    test_drain_pause();
    send_random(100);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/msct_pkg.sv
rtl/minute_step_countdown_timer_core.sv
sim/testbench.sv
